[design/bgls_pkg.sv]
// shared constants and widths for the byte-granular lifo stack
`default_nettype none

package bgls_pkg;

  localparam int STORE_BYTES_DEF = 64;
  // largest push or pop accepted, at most LANES
  localparam int MAX_ITEM_BYTES  = 8;
  // byte lanes of the store, one bank each
  localparam int LANES           = 8;
  localparam int LANE_W          = 3;
  localparam int CNT_W           = 4;
  localparam int FILL_W          = 7;
  localparam int DATA_W          = 64;
  localparam int CAP_RESET       = 64;

  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_POP  = 1'b1;

endpackage

`default_nettype wire

[design/bgls_bank.sv]
// one byte lane of the stack store: one write port, one registered read port
`default_nettype none

module bgls_bank #(
  parameter int ROWS  = 8,
  parameter int ROW_W = 3
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [ROW_W-1:0] wr_row,
  input  wire logic [7:0]       wr_data,
  input  wire logic [ROW_W-1:0] rd_row,
  output logic      [7:0]       rd_data
);

  logic [7:0] mem [ROWS];
  logic [7:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_row] <= wr_data;
    end
    rd_data_r <= mem[rd_row];
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

[design/byte_granular_lifo_stack_core.sv]
// byte-granular lifo stack: variable size push and pop over eight byte banks
// a result strobes in the cycle after start, for exactly one cycle
// throughput: one transaction per cycle, busy stays low; set by the single
//   write and registered read port of each byte bank
// reset: fill level cleared, capacity back to 64 bytes (or the store size);
//   store contents are undefined until pushed, the receiver cannot stall
`default_nettype none

module byte_granular_lifo_stack_core #(
  parameter int STORE_BYTES = bgls_pkg::STORE_BYTES_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic                          in_mode,
  input  wire logic [bgls_pkg::CNT_W-1:0]    in_byte_count,
  input  wire logic [bgls_pkg::DATA_W-1:0]   in_push_data,
  output logic                               out_strobe,
  output logic                               out_ok,
  output logic      [bgls_pkg::DATA_W-1:0]   out_pop_data,
  output logic      [bgls_pkg::FILL_W-1:0]   out_fill_bytes,
  output logic                               out_is_empty,
  output logic                               out_is_full,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [bgls_pkg::FILL_W-1:0]   cfg_data
);

  import bgls_pkg::*;

  localparam int ROWS    = (STORE_BYTES + LANES - 1) / LANES;
  localparam int ROW_W   = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int CAP_LIM = (STORE_BYTES > (2 ** FILL_W - 1)) ? (2 ** FILL_W - 1) : STORE_BYTES;
  localparam int CAP_RST = (CAP_RESET > STORE_BYTES) ? STORE_BYTES : CAP_RESET;
  localparam logic [FILL_W-1:0] CAP_LIM_W = FILL_W'(CAP_LIM);
  localparam logic [FILL_W-1:0] CAP_RST_W = FILL_W'(CAP_RST);

  logic              go;
  logic              cfg_go;
  logic [FILL_W-1:0] fill_r, fill_nxt;
  logic [FILL_W-1:0] cap_r, cap_nxt;
  logic              op_ok;
  logic [FILL_W:0]   push_sum;
  logic [FILL_W-1:0] base;
  logic [FILL_W-1:0] cnt_ext;

  logic              out_strobe_r;
  logic              out_ok_r;
  logic [FILL_W-1:0] out_fill_r;
  logic              out_empty_r;
  logic              out_full_r;
  logic              pop_sel_r;
  logic [LANE_W-1:0] pop_base_r;
  logic [CNT_W-1:0]  pop_cnt_r;

  logic [ROW_W-1:0]  wr_row  [LANES];
  logic [ROW_W-1:0]  rd_row  [LANES];
  logic [7:0]        wr_byte [LANES];
  logic              wr_en   [LANES];
  logic [7:0]        rd_byte [LANES];

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;
  assign go        = start && !busy;
  assign cfg_go    = cfg_valid && cfg_ready;

  assign cnt_ext  = FILL_W'(in_byte_count);
  assign push_sum = {1'b0, fill_r} + {1'b0, cnt_ext};

  always_comb begin
    if (in_byte_count > CNT_W'(MAX_ITEM_BYTES)) begin
      op_ok = 1'b0;
    end else if (in_mode == OP_PUSH) begin
      op_ok = !(push_sum > {1'b0, cap_r});
    end else begin
      op_ok = !(cnt_ext > fill_r);
    end
  end

  // lowest position touched: the old top for a push, the new top for a pop
  assign base = (in_mode == OP_PUSH) ? fill_r : (fill_r - cnt_ext);

  always_comb begin
    fill_nxt = fill_r;
    cap_nxt  = cap_r;
    if (cfg_go) begin
      cap_nxt  = (cfg_data > CAP_LIM_W) ? CAP_LIM_W : cfg_data;
      fill_nxt = '0;
    end else if (go && op_ok) begin
      fill_nxt = (in_mode == OP_PUSH) ? push_sum[FILL_W-1:0] : base;
    end
  end

  // each lane holds at most one byte of a transaction; the byte nearest the
  // top of the stack is the low byte of the value
  always_comb begin
    logic [LANE_W-1:0] d;
    logic [LANE_W-1:0] idx;
    logic [FILL_W-1:0] pos;
    for (int b = 0; b < LANES; b++) begin
      d          = LANE_W'(b) - base[LANE_W-1:0];
      pos        = base + FILL_W'(d);
      idx        = LANE_W'(in_byte_count - CNT_W'(1) - CNT_W'(d));
      wr_row[b]  = ROW_W'(pos >> LANE_W);
      rd_row[b]  = ROW_W'(pos >> LANE_W);
      wr_byte[b] = in_push_data[idx*8 +: 8];
      wr_en[b]   = go && op_ok && (in_mode == OP_PUSH) && (CNT_W'(d) < in_byte_count);
    end
  end

  for (genvar g = 0; g < LANES; g++) begin : g_bank
    bgls_bank #(
      .ROWS  (ROWS),
      .ROW_W (ROW_W)
    ) u_bank (
      .clk     (clk),
      .wr_en   (wr_en[g]),
      .wr_row  (wr_row[g]),
      .wr_data (wr_byte[g]),
      .rd_row  (rd_row[g]),
      .rd_data (rd_byte[g])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r       <= '0;
      cap_r        <= CAP_RST_W;
      out_strobe_r <= 1'b0;
      pop_sel_r    <= 1'b0;
    end else begin
      fill_r       <= fill_nxt;
      cap_r        <= cap_nxt;
      out_strobe_r <= go;
      pop_sel_r    <= go && op_ok && (in_mode == OP_POP);
    end
    out_ok_r    <= op_ok;
    out_fill_r  <= fill_nxt;
    out_empty_r <= (fill_nxt == '0);
    out_full_r  <= (fill_nxt == cap_r);
    pop_base_r  <= base[LANE_W-1:0];
    pop_cnt_r   <= in_byte_count;
  end

  // put the banked bytes back in little-endian order
  always_comb begin
    logic [LANE_W-1:0] lane;
    out_pop_data = '0;
    for (int i = 0; i < LANES; i++) begin
      lane = LANE_W'(pop_cnt_r - CNT_W'(1) - CNT_W'(i)) + pop_base_r;
      if (pop_sel_r && (CNT_W'(i) < pop_cnt_r)) begin
        out_pop_data[i*8 +: 8] = rd_byte[lane];
      end
    end
  end

  assign out_strobe     = out_strobe_r;
  assign out_ok         = out_ok_r;
  assign out_fill_bytes = out_fill_r;
  assign out_is_empty   = out_empty_r;
  assign out_is_full    = out_full_r;

endmodule

`default_nettype wire

[dv/byte_granular_lifo_stack_core_test.sv]
// self-checking testbench for the byte-granular lifo stack core
`default_nettype none

module byte_granular_lifo_stack_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  import bgls_pkg::*;

  typedef struct packed {
    logic              ok;
    logic [DATA_W-1:0] pop_data;
    logic [FILL_W-1:0] fill_bytes;
    logic              is_empty;
    logic              is_full;
  } stack_result_t;

  typedef struct packed {
    logic              mode;
    logic [CNT_W-1:0]  count;
    logic [DATA_W-1:0] data;
    logic              fixed;
    stack_result_t     want;
  } stim_row_t;

  localparam int DIRECTED_ROWS   = 25;
  localparam int PHASES          = 10;
  localparam int ITEMS_PER_PHASE = 85;
  localparam int CYCLE_LIMIT     = 200000;

  logic              clk           = 1'b0;
  logic              rst_n         = 1'b0;
  logic              start         = 1'b0;
  logic              in_mode       = OP_PUSH;
  logic [CNT_W-1:0]  in_byte_count = '0;
  logic [DATA_W-1:0] in_push_data  = '0;
  logic              cfg_valid     = 1'b0;
  logic [FILL_W-1:0] cfg_data      = '0;
  logic              busy;
  logic              out_strobe;
  logic              out_ok;
  logic [DATA_W-1:0] out_pop_data;
  logic [FILL_W-1:0] out_fill_bytes;
  logic              out_is_empty;
  logic              out_is_full;
  logic              cfg_ready;

  // shadow copy of the stack
  logic [7:0]    shadow_bytes [STORE_BYTES_DEF];
  int            shadow_fill = 0;
  int            shadow_cap  = CAP_RESET;
  stack_result_t pending_results [$];
  stack_result_t head_result;
  int            mismatch_count = 0;
  int            cycle_count    = 0;

  byte_granular_lifo_stack_core uut (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_mode       (in_mode),
    .in_byte_count (in_byte_count),
    .in_push_data  (in_push_data),
    .out_strobe    (out_strobe),
    .out_ok        (out_ok),
    .out_pop_data  (out_pop_data),
    .out_fill_bytes(out_fill_bytes),
    .out_is_empty  (out_is_empty),
    .out_is_full   (out_is_full),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic stack_result_t stack_predict(input logic mode,
                                                  input logic [CNT_W-1:0] count,
                                                  input logic [DATA_W-1:0] data);
    stack_result_t r;
    int            n;
    int            i;
    r = '0;
    n = int'(count);
    if (n > MAX_ITEM_BYTES) begin
      r.ok = 1'b0;
    end else if (mode == OP_PUSH) begin
      if (shadow_fill + n <= shadow_cap) begin
        // byte 0 lands on top so a same-size pop returns it unchanged
        for (i = 0; i < n; i++) shadow_bytes[shadow_fill + n - 1 - i] = data[8*i +: 8];
        shadow_fill += n;
        r.ok = 1'b1;
      end
    end else if (n <= shadow_fill) begin
      for (i = 0; i < n; i++) r.pop_data[8*i +: 8] = shadow_bytes[shadow_fill - 1 - i];
      shadow_fill -= n;
      r.ok = 1'b1;
    end
    r.fill_bytes = FILL_W'(shadow_fill);
    r.is_empty   = (shadow_fill == 0);
    r.is_full    = (shadow_fill == shadow_cap);
    return r;
  endfunction

  task automatic send_op(input logic mode, input logic [CNT_W-1:0] count,
                         input logic [DATA_W-1:0] data, input logic fixed,
                         input stack_result_t want);
    stack_result_t r;
    start         <= 1'b1;
    in_mode       <= mode;
    in_byte_count <= count;
    in_push_data  <= data;
    do @(posedge clk); while (busy);
    r = stack_predict(mode, count, data);
    pending_results.push_back(fixed ? want : r);
  endtask

  task automatic pause_sender(input logic no_idle);
    if (!no_idle && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
  endtask

  task automatic drain_results();
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_capacity(input logic [FILL_W-1:0] value);
    start <= 1'b0;
    @(posedge clk);
    drain_results();
    repeat (2) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid   <= 1'b0;
    shadow_cap  = (int'(value) > STORE_BYTES_DEF) ? STORE_BYTES_DEF : int'(value);
    shadow_fill = 0;
  endtask

  // result checker
  always @(posedge clk) begin
    if (rst_n && out_strobe) begin
      if (pending_results.size() == 0) begin
        $error("result strobe with no transaction pending");
        mismatch_count++;
      end else begin
        head_result = pending_results.pop_front();
        if (out_ok !== head_result.ok) begin
          $error("ok expected %0d got %0d", head_result.ok, out_ok);
          mismatch_count++;
        end
        if (out_pop_data !== head_result.pop_data) begin
          $error("pop_data expected %h got %h", head_result.pop_data, out_pop_data);
          mismatch_count++;
        end
        if (out_fill_bytes !== head_result.fill_bytes) begin
          $error("fill_bytes expected %0d got %0d", head_result.fill_bytes, out_fill_bytes);
          mismatch_count++;
        end
        if (out_is_empty !== head_result.is_empty) begin
          $error("is_empty expected %0d got %0d", head_result.is_empty, out_is_empty);
          mismatch_count++;
        end
        if (out_is_full !== head_result.is_full) begin
          $error("is_full expected %0d got %0d", head_result.is_full, out_is_full);
          mismatch_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL byte_granular_lifo_stack_core");
      $finish;
    end
  end

  initial begin
    stim_row_t         rows [DIRECTED_ROWS];
    logic [FILL_W-1:0] caps [PHASES];
    int                k;
    int                p;
    int                j;
    int                n;
    int                sel;
    logic              m;
    logic [DATA_W-1:0] d;

    // fixed rows: ok, pop_data, fill, empty, full
    rows = '{
      '{OP_POP,  4'd1,  64'h0, 1'b1, '{1'b0, 64'h0, 7'd0, 1'b1, 1'b0}},
      '{OP_POP,  4'd0,  64'h0, 1'b1, '{1'b1, 64'h0, 7'd0, 1'b1, 1'b0}},
      '{OP_PUSH, 4'd0,  64'hffff_ffff_ffff_ffff, 1'b1, '{1'b1, 64'h0, 7'd0, 1'b1, 1'b0}},
      '{OP_PUSH, 4'd9,  64'h1234_5678_9abc_def0, 1'b1, '{1'b0, 64'h0, 7'd0, 1'b1, 1'b0}},
      '{OP_PUSH, 4'd15, 64'hffff_ffff_ffff_ffff, 1'b1, '{1'b0, 64'h0, 7'd0, 1'b1, 1'b0}},
      '{OP_POP,  4'd15, 64'h0, 1'b1, '{1'b0, 64'h0, 7'd0, 1'b1, 1'b0}},
      '{OP_PUSH, 4'd8,  64'hffff_ffff_ffff_ffff, 1'b1, '{1'b1, 64'h0, 7'd8, 1'b0, 1'b0}},
      '{OP_PUSH, 4'd1,  64'hffff_ffff_ffff_ff5a, 1'b0, '0},
      '{OP_PUSH, 4'd8,  64'h0123_4567_89ab_cdef, 1'b0, '0},
      '{OP_POP,  4'd8,  64'h0, 1'b0, '0},
      '{OP_POP,  4'd9,  64'h0, 1'b1, '{1'b0, 64'h0, 7'd9, 1'b0, 1'b0}},
      '{OP_POP,  4'd1,  64'h0, 1'b0, '0},
      '{OP_POP,  4'd8,  64'h0, 1'b0, '0},
      '{OP_PUSH, 4'd8,  64'h8000_0000_0000_0001, 1'b0, '0},
      '{OP_PUSH, 4'd8,  64'h0, 1'b0, '0},
      '{OP_PUSH, 4'd8,  64'hffff_ffff_ffff_ffff, 1'b0, '0},
      '{OP_PUSH, 4'd8,  64'hdead_beef_cafe_f00d, 1'b0, '0},
      '{OP_PUSH, 4'd8,  64'h1111_2222_3333_4444, 1'b0, '0},
      '{OP_PUSH, 4'd8,  64'h0102_0304_0506_0708, 1'b0, '0},
      '{OP_PUSH, 4'd8,  64'haaaa_aaaa_aaaa_aaaa, 1'b0, '0},
      '{OP_PUSH, 4'd8,  64'h5555_5555_5555_5555, 1'b0, '0},
      '{OP_PUSH, 4'd1,  64'h77, 1'b1, '{1'b0, 64'h0, 7'd64, 1'b0, 1'b1}},
      '{OP_PUSH, 4'd0,  64'h0, 1'b1, '{1'b1, 64'h0, 7'd64, 1'b0, 1'b1}},
      '{OP_POP,  4'd3,  64'h0, 1'b0, '0},
      '{OP_POP,  4'd5,  64'h0, 1'b0, '0}
    };
    // zero, one, saturating values, odd sizes, two random picks, and back to full size last
    caps = '{7'd0, 7'd1, 7'd127, 7'd8, 7'd65, 7'd23, 7'd0, 7'd0, 7'd40, 7'd64};
    caps[6] = FILL_W'($urandom_range(2, 127));
    caps[7] = FILL_W'($urandom_range(2, 127));

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (k = 0; k < DIRECTED_ROWS; k++) begin
      send_op(rows[k].mode, rows[k].count, rows[k].data, rows[k].fixed, rows[k].want);
      pause_sender(1'b0);
    end

    for (p = 0; p < PHASES; p++) begin
      write_capacity(caps[p]);
      for (j = 0; j < ITEMS_PER_PHASE; j++) begin
        sel = $urandom_range(0, 99);
        if (sel < 6) n = 0;
        else if (sel < 12) n = $urandom_range(9, 15);
        else n = $urandom_range(1, 8);
        // lean toward pops as the stack fills, with some contrary picks
        m = ($urandom_range(0, shadow_cap) < shadow_fill) ? OP_POP : OP_PUSH;
        if ($urandom_range(0, 9) == 0) m = ~m;
        d = {$urandom, $urandom};
        send_op(m, CNT_W'(n), d, 1'b0, '0);
        pause_sender(p == PHASES - 1);
      end
    end

    start <= 1'b0;
    drain_results();
    repeat (4) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("PASS byte_granular_lifo_stack_core");
    end else begin
      $display("FAIL byte_granular_lifo_stack_core");
    end
    $finish;
  end

endmodule

`default_nettype wire

[sim.f]
design/bgls_pkg.sv
design/bgls_bank.sv
design/byte_granular_lifo_stack_core.sv
dv/byte_granular_lifo_stack_core_test.sv
